@@ src/sttb_pkg.sv @@
// Shared constants for the sorted best-time table: opcodes, status codes,
// field widths and parameter defaults. No dependencies.
package sttb_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NAME_BYTES_DEF  = 32;

    localparam int NAME_FULL_W = 248;
    localparam int TIME_W      = 24;
    localparam int SPEED_W     = 16;
    localparam int RANK_W      = 7;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_IMPROVED = 3'd0;
    localparam logic [2:0] ST_KEPT     = 3'd1;
    localparam logic [2:0] ST_ADDED    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

endpackage

@@ src/sorted_best_time_table.sv @@
// Top level of the sorted best-time table: sequencer and entry memory.
// Uses sttb_pkg, sttb_key and sttb_ram.
//
// Entries live in one memory, one entry (key, time, speed) per row, kept in
// ascending time order. A store scans rows one per cycle looking for the name
// and the insertion point, then moves the rows between the insertion point
// and the old or end position up by one, one row per cycle, and writes the
// new row. A read walks from the index down over the entries tied with it
// to find the first tied index; clear and an empty-index read are answered
// straight from idle. The entry memory has a single read port, so each walk
// reads one row at a time. One word is taken at a time; the next is taken
// once the result word has been delivered. The memory needs no clearing pass.
module sorted_best_time_table #(
    parameter int MAX_ENTRIES = sttb_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_BYTES  = sttb_pkg::NAME_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   op,
    input  logic [63:0]  name_word0,
    input  logic [63:0]  name_word1,
    input  logic [63:0]  name_word2,
    input  logic [55:0]  name_word3,
    input  logic [23:0]  time_tenths,
    input  logic [15:0]  speed_tenths,
    input  logic [5:0]   read_index,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic [63:0]  out_name_word0,
    output logic [63:0]  out_name_word1,
    output logic [63:0]  out_name_word2,
    output logic [55:0]  out_name_word3,
    output logic [23:0]  record_time,
    output logic [15:0]  best_speed,
    output logic [6:0]   tied_rank,
    output logic [6:0]   entry_count
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W = (NAME_BYTES - 1) * 8;
    localparam int TW    = sttb_pkg::TIME_W;
    localparam int SW    = sttb_pkg::SPEED_W;
    localparam int ENT_W = KEY_W + TW + SW;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_RWALK
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TW-1:0]    time_reg, time_next;
    logic [SW-1:0]    speed_reg, speed_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             iss_done_reg, iss_done_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             pos_found_reg, pos_found_next;
    logic [2:0]       pend_reg, pend_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic             have_reg, have_next;
    logic [TW-1:0]    tgt_time_reg, tgt_time_next;

    logic                             out_valid_reg, out_valid_next;
    logic [2:0]                       status_reg, status_next;
    logic [sttb_pkg::NAME_FULL_W-1:0] name_reg, name_next;
    logic [TW-1:0]                    btime_reg, btime_next;
    logic [SW-1:0]                    bspeed_reg, bspeed_next;
    logic [6:0]                       rank_reg, rank_next;
    logic [6:0]                       count_reg, count_next;

    logic [KEY_W-1:0] in_key;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [ENT_W-1:0] ram_wr_data, ram_rd_data;
    logic [KEY_W-1:0] ent_key;
    logic [TW-1:0]    ent_time;
    logic [SW-1:0]    ent_speed;

    sttb_key #(
        .NAME_BYTES (NAME_BYTES)
    ) u_key (
        .name_word0 (name_word0),
        .name_word1 (name_word1),
        .name_word2 (name_word2),
        .name_word3 (name_word3),
        .key        (in_key)
    );

    sttb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ent_key   = ram_rd_data[ENT_W-1 -: KEY_W];
    assign ent_time  = ram_rd_data[SW +: TW];
    assign ent_speed = ram_rd_data[SW-1:0];

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        logic             le;
        logic [CNT_W-1:0] pos_here;
        logic [CNT_W-1:0] p_sel;
        logic [CNT_W-1:0] e_sel;
        logic             go_shift;

        le       = 1'b0;
        pos_here = '0;
        p_sel    = '0;
        e_sel    = '0;
        go_shift = 1'b0;

        state_next     = state_reg;
        used_next      = used_reg;
        key_next       = key_reg;
        time_next      = time_reg;
        speed_next     = speed_reg;
        iss_next       = iss_reg;
        iss_done_next  = iss_done_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        have_next      = have_reg;
        tgt_time_next  = tgt_time_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        name_next      = name_reg;
        btime_next     = btime_reg;
        bspeed_next    = bspeed_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg[IDX_W-1:0];
        ram_wr_data = {key_reg, time_reg, speed_reg};
        ram_rd_addr = iss_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    key_next       = in_key;
                    time_next      = time_tenths;
                    speed_next     = speed_tenths;
                    name_next      = '0;
                    btime_next     = '0;
                    bspeed_next    = '0;
                    rank_next      = '0;
                    iss_done_next  = 1'b0;
                    pos_found_next = 1'b0;
                    have_next      = 1'b0;
                    unique case (op)
                        sttb_pkg::OP_STORE:
                        begin
                            iss_next = '0;
                            if (used_reg == '0)
                            begin
                                pos_next   = '0;
                                pend_next  = sttb_pkg::ST_ADDED;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        sttb_pkg::OP_READ:
                        begin
                            if (int'(read_index) < int'(used_reg))
                            begin
                                iss_next   = CNT_W'(read_index);
                                first_next = CNT_W'(read_index);
                                state_next = S_RWALK;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = sttb_pkg::ST_EMPTY;
                                count_next     = 7'(used_reg);
                            end
                        end
                        sttb_pkg::OP_CLEAR:
                        begin
                            used_next      = '0;
                            out_valid_next = 1'b1;
                            status_next    = sttb_pkg::ST_CLEARED;
                            count_next     = '0;
                        end
                        default:
                        begin
                            // Unused opcode: the word is dropped without a result.
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (iss_reg < used_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg;
                    iss_next       = iss_reg + ONE;
                end
                if (chk_valid_reg)
                begin
                    le       = time_reg <= ent_time;
                    pos_here = pos_found_reg ? pos_reg : chk_idx_reg;
                    if (le && !pos_found_reg)
                    begin
                        pos_found_next = 1'b1;
                        pos_next       = chk_idx_reg;
                    end
                    if (ent_key == key_reg)
                    begin
                        if (time_reg < ent_time)
                        begin
                            // The new slot is never past the old one, so only the
                            // rows between them move.
                            pend_next = sttb_pkg::ST_IMPROVED;
                            p_sel     = pos_here;
                            e_sel     = chk_idx_reg;
                            go_shift  = 1'b1;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            status_next    = sttb_pkg::ST_KEPT;
                            count_next     = 7'(used_reg);
                            state_next     = S_IDLE;
                        end
                    end
                    else if (chk_idx_reg == used_reg - ONE)
                    begin
                        if (used_reg == FULL_CNT)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = sttb_pkg::ST_FULL;
                            count_next     = 7'(used_reg);
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            pend_next = sttb_pkg::ST_ADDED;
                            p_sel     = (pos_found_reg || le) ? pos_here : used_reg;
                            e_sel     = used_reg;
                            go_shift  = 1'b1;
                        end
                    end
                end
                if (go_shift)
                begin
                    pos_next       = p_sel;
                    chk_valid_next = 1'b0;
                    if (e_sel == p_sel)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        iss_next      = e_sel - ONE;
                        iss_done_next = 1'b0;
                        state_next    = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                if (!iss_done_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg;
                    if (iss_reg == pos_reg)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_next = iss_reg - ONE;
                    end
                end
                if (chk_valid_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = IDX_W'(chk_idx_reg + ONE);
                    ram_wr_data = ram_rd_data;
                    if (chk_idx_reg == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                ram_wr_en      = 1'b1;
                out_valid_next = 1'b1;
                status_next    = pend_reg;
                if (pend_reg == sttb_pkg::ST_ADDED)
                begin
                    used_next  = used_reg + ONE;
                    count_next = 7'(used_reg + ONE);
                end
                else
                begin
                    count_next = 7'(used_reg);
                end
                state_next = S_IDLE;
            end

            S_RWALK:
            begin
                if (!iss_done_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg;
                    if (iss_reg == '0)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_next = iss_reg - ONE;
                    end
                end
                if (chk_valid_reg)
                begin
                    status_next = sttb_pkg::ST_READ;
                    count_next  = 7'(used_reg);
                    if (!have_reg)
                    begin
                        // First word back is the requested entry itself.
                        have_next     = 1'b1;
                        tgt_time_next = ent_time;
                        name_next     = sttb_pkg::NAME_FULL_W'(ent_key);
                        btime_next    = ent_time;
                        bspeed_next   = ent_speed;
                        if (chk_idx_reg == '0)
                        begin
                            rank_next      = 7'd1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else if (ent_time == tgt_time_reg)
                    begin
                        first_next = chk_idx_reg;
                        if (chk_idx_reg == '0)
                        begin
                            rank_next      = 7'd1;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        rank_next      = 7'(first_reg + ONE);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            key_reg       <= '0;
            time_reg      <= '0;
            speed_reg     <= '0;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            pend_reg      <= sttb_pkg::ST_ADDED;
            first_reg     <= '0;
            have_reg      <= 1'b0;
            tgt_time_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            name_reg      <= '0;
            btime_reg     <= '0;
            bspeed_reg    <= '0;
            rank_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            key_reg       <= key_next;
            time_reg      <= time_next;
            speed_reg     <= speed_next;
            iss_reg       <= iss_next;
            iss_done_reg  <= iss_done_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            pos_reg       <= pos_next;
            pos_found_reg <= pos_found_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            have_reg      <= have_next;
            tgt_time_reg  <= tgt_time_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            name_reg      <= name_next;
            btime_reg     <= btime_next;
            bspeed_reg    <= bspeed_next;
            rank_reg      <= rank_next;
            count_reg     <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_name_word0 = name_reg[63:0];
    assign out_name_word1 = name_reg[127:64];
    assign out_name_word2 = name_reg[191:128];
    assign out_name_word3 = name_reg[247:192];
    assign record_time    = btime_reg;
    assign best_speed     = bspeed_reg;
    assign tied_rank      = rank_reg;
    assign entry_count    = count_reg;

endmodule

@@ src/sttb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/sttb_key.sv @@
// Builds the name key from the input words: bytes after the first zero byte
// and bytes past the key length read as zero. Uses sttb_pkg.
module sttb_key #(
    parameter int NAME_BYTES = sttb_pkg::NAME_BYTES_DEF
) (
    input  logic [63:0]                  name_word0,
    input  logic [63:0]                  name_word1,
    input  logic [63:0]                  name_word2,
    input  logic [55:0]                  name_word3,
    output logic [(NAME_BYTES-1)*8-1:0]  key
);

    localparam int KEY_BYTES = NAME_BYTES - 1;

    logic [sttb_pkg::NAME_FULL_W-1:0] src;

    assign src = {name_word3, name_word2, name_word1, name_word0};

    always_comb
    begin
        logic live;
        live = 1'b1;
        key  = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (src[b*8 +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                key[b*8 +: 8] = src[b*8 +: 8];
            end
        end
    end

endmodule

@@ tb/sorted_best_time_table_tb.sv @@
// Self-checking testbench for the sorted best-time table.
// Depends on sttb_pkg and sorted_best_time_table; a built-in table model
// predicts every result word.
`timescale 1ns / 1ps

module sorted_best_time_table_tb;

    localparam int  ROSTER = 100;
    localparam int  TABLE_SIZE = sttb_pkg::MAX_ENTRIES_DEF;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] w0, w1, w2;
        logic [55:0] w3;
        logic [23:0] t;
        logic [15:0] s;
        logic [5:0]  idx;
    } cmd_t;

    typedef struct {
        logic [2:0]   st;
        logic [247:0] name;
        logic [23:0]  t;
        logic [15:0]  s;
        logic [6:0]   rank;
        logic [6:0]   cnt;
    } resp_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0]  op;
    logic [63:0] name_word0, name_word1, name_word2;
    logic [55:0] name_word3;
    logic [23:0] time_tenths;
    logic [15:0] speed_tenths;
    logic [5:0]  read_index;
    logic [2:0]  status;
    logic [63:0] out_name_word0, out_name_word1, out_name_word2;
    logic [55:0] out_name_word3;
    logic [23:0] record_time;
    logic [15:0] best_speed;
    logic [6:0]  tied_rank, entry_count;

    sorted_best_time_table dut (.*);

    // Model of the table contents.
    logic [247:0] board_key[TABLE_SIZE];
    logic [23:0]  board_time[TABLE_SIZE];
    logic [15:0]  board_speed[TABLE_SIZE];
    int           board_used;
    int           status_seen[8];

    cmd_t  pending_cmds[$];
    resp_t expected_resps[$];
    cmd_t  cur_cmd;

    logic [247:0] roster_key[ROSTER];
    int           roster_len[ROSTER];

    int     send_gap, recv_wait, hold_cnt;
    bit     send_idle, recv_idle, held;
    int     words_out, mismatches;
    longint cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t mk(logic [1:0] o, logic [247:0] n, logic [23:0] t,
                                logic [15:0] s, logic [5:0] idx);
        cmd_t c;
        c.op = o;
        c.w0 = n[63:0];
        c.w1 = n[127:64];
        c.w2 = n[191:128];
        c.w3 = n[247:192];
        c.t = t;
        c.s = s;
        c.idx = idx;
        return c;
    endfunction

    // Only bytes before the first zero byte form the key.
    function automatic logic [247:0] key_of(cmd_t c);
        logic [247:0] raw, k;
        bit ended;
        raw = {c.w3, c.w2, c.w1, c.w0};
        k = '0;
        ended = 0;
        for (int b = 0; b < 31; b++)
        begin
            if (raw[8*b +: 8] == 8'd0)
                ended = 1;
            if (!ended)
                k[8*b +: 8] = raw[8*b +: 8];
        end
        return k;
    endfunction

    task automatic board_apply(cmd_t c);
        resp_t r;
        logic [247:0] k;
        int hit, pos, first;
        r = '{default: '0};
        if (c.op == sttb_pkg::OP_STORE)
        begin
            k = key_of(c);
            hit = -1;
            for (int i = 0; i < board_used; i++)
                if (hit < 0 && board_key[i] == k)
                    hit = i;
            if (hit >= 0 && c.t >= board_time[hit])
            begin
                r.st = sttb_pkg::ST_KEPT;
            end
            else if (hit < 0 && board_used >= TABLE_SIZE)
            begin
                r.st = sttb_pkg::ST_FULL;
            end
            else
            begin
                r.st = (hit >= 0) ? sttb_pkg::ST_IMPROVED : sttb_pkg::ST_ADDED;
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < board_used; i++)
                    begin
                        board_key[i] = board_key[i+1];
                        board_time[i] = board_time[i+1];
                        board_speed[i] = board_speed[i+1];
                    end
                    board_used--;
                end
                pos = 0;
                while (pos < board_used && c.t > board_time[pos])
                    pos++;
                for (int i = board_used; i > pos; i--)
                begin
                    board_key[i] = board_key[i-1];
                    board_time[i] = board_time[i-1];
                    board_speed[i] = board_speed[i-1];
                end
                board_key[pos] = k;
                board_time[pos] = c.t;
                board_speed[pos] = c.s;
                board_used++;
            end
        end
        else if (c.op == sttb_pkg::OP_READ)
        begin
            if (c.idx < board_used)
            begin
                first = c.idx;
                while (first > 0 && board_time[first-1] == board_time[c.idx])
                    first--;
                r.st = sttb_pkg::ST_READ;
                r.name = board_key[c.idx];
                r.t = board_time[c.idx];
                r.s = board_speed[c.idx];
                r.rank = 7'(first + 1);
            end
            else
            begin
                r.st = sttb_pkg::ST_EMPTY;
            end
        end
        else if (c.op == sttb_pkg::OP_CLEAR)
        begin
            board_used = 0;
            r.st = sttb_pkg::ST_CLEARED;
        end
        else
        begin
            return;
        end
        r.cnt = 7'(board_used);
        status_seen[r.st]++;
        expected_resps.push_back(r);
    endtask

    // A roster name, sometimes with junk after its terminating zero byte.
    function automatic logic [247:0] roster_name(int k);
        logic [247:0] n;
        n = roster_key[k];
        if (roster_len[k] < 30 && $urandom_range(0, 1))
            for (int b = roster_len[k] + 1; b < 31; b++)
                n[8*b +: 8] = 8'($urandom);
        return n;
    endfunction

    function automatic logic [23:0] draw_time();
        if ($urandom_range(0, 1))
            return 24'($urandom_range(0, 20));
        return 24'($urandom);
    endfunction

    function automatic logic [247:0] noise_name();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, 24'($urandom)};
    endfunction

    task automatic queue_mixed(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                pending_cmds.push_back(mk(sttb_pkg::OP_STORE,
                    roster_name($urandom_range(0, ROSTER - 1)),
                    draw_time(), 16'($urandom), 6'($urandom)));
            else if (r < 90)
                pending_cmds.push_back(mk(sttb_pkg::OP_READ, noise_name(), 24'($urandom),
                    16'($urandom), 6'($urandom)));
            else if (r < 92)
                pending_cmds.push_back(mk(sttb_pkg::OP_CLEAR, noise_name(), 24'($urandom),
                    16'($urandom), 6'($urandom)));
            else if (r < 95)
                pending_cmds.push_back(mk(OP_SPARE, noise_name(), 24'($urandom),
                    16'($urandom), 6'($urandom)));
            else
                pending_cmds.push_back(mk(sttb_pkg::OP_STORE, noise_name(), draw_time(),
                    16'($urandom), 6'($urandom)));
        end
    endtask

    initial
    begin
        logic [247:0] name_a, name_b, name_c, name_d;
        int len, kind;
        board_used = 0;
        words_out = 0;
        mismatches = 0;
        for (int i = 0; i < ROSTER; i++)
        begin
            len = (i % 10 == 0) ? 31 : $urandom_range(1, 31);
            roster_len[i] = len;
            roster_key[i] = '0;
            for (int b = 0; b < len; b++)
                roster_key[i][8*b +: 8] = 8'($urandom_range(1, 255));
        end
        name_a = 248'h61;
        name_b = '1;
        name_c = 248'h63;
        name_d = 248'h64;

        pending_cmds.push_back(mk(sttb_pkg::OP_READ, '0, '0, '0, 6'd0));
        pending_cmds.push_back(mk(sttb_pkg::OP_CLEAR, '0, '0, '0, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_a, 24'd0, 16'd0, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_READ, '0, '0, '0, 6'd0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_a, '1, '1, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_b, '1, '1, '1));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_c, 24'd5, 16'd3, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_d, 24'd5, 16'd4, '0));
        // Same key as name_a: junk follows the terminating zero byte.
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_a | (248'hAB << 16), 24'd0,
                                  16'd9, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_c, 24'd4, 16'd7, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, '0, 24'd7, 16'd1, '0));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(sttb_pkg::OP_READ, '0, '0, '0, 6'(i)));
        pending_cmds.push_back(mk(sttb_pkg::OP_READ, '1, '1, '1, 6'd63));
        pending_cmds.push_back(mk(OP_SPARE, '1, '1, '1, '1));
        pending_cmds.push_back(mk(sttb_pkg::OP_STORE, name_b, 24'hFFFFFE, 16'd2, '0));
        pending_cmds.push_back(mk(sttb_pkg::OP_READ, '0, '0, '0, 6'd5));
        pending_cmds.push_back(mk(sttb_pkg::OP_CLEAR, '1, '1, '1, '1));
        pending_cmds.push_back(mk(sttb_pkg::OP_READ, '0, '0, '0, 6'd0));

        while (pending_cmds.size() < 1620)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                pending_cmds.push_back(mk(sttb_pkg::OP_CLEAR, noise_name(), '0, '0, '0));
            end
            else if (kind < 3)
            begin
                // Fill past capacity, then walk the whole table.
                for (int i = 0; i < 70; i++)
                    pending_cmds.push_back(mk(sttb_pkg::OP_STORE, roster_name(i),
                        draw_time(), 16'($urandom), 6'($urandom)));
                for (int i = 0; i < TABLE_SIZE; i++)
                    pending_cmds.push_back(mk(sttb_pkg::OP_READ, noise_name(), '0, '0,
                        6'(i)));
            end
            else
            begin
                queue_mixed(20);
            end
        end

        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        do @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_resps.size() != 0);
        repeat (200) @(posedge clk);
        $display("Checked %0d result words: %0d added, %0d improved, %0d kept, %0d refused full,",
                 words_out, status_seen[sttb_pkg::ST_ADDED],
                 status_seen[sttb_pkg::ST_IMPROVED],
                 status_seen[sttb_pkg::ST_KEPT], status_seen[sttb_pkg::ST_FULL]);
        $display("  %0d entry reads, %0d empty reads, %0d clears; %0d mismatches.",
                 status_seen[sttb_pkg::ST_READ], status_seen[sttb_pkg::ST_EMPTY],
                 status_seen[sttb_pkg::ST_CLEARED], mismatches);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Driver: one word from the pending queue at a time, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            op <= '0;
            name_word0 <= '0;
            name_word1 <= '0;
            name_word2 <= '0;
            name_word3 <= '0;
            time_tenths <= '0;
            speed_tenths <= '0;
            read_index <= '0;
            send_gap <= 0;
            send_idle <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                board_apply(cur_cmd);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cur_cmd <= pending_cmds[0];
                    op <= pending_cmds[0].op;
                    name_word0 <= pending_cmds[0].w0;
                    name_word1 <= pending_cmds[0].w1;
                    name_word2 <= pending_cmds[0].w2;
                    name_word3 <= pending_cmds[0].w3;
                    time_tenths <= pending_cmds[0].t;
                    speed_tenths <= pending_cmds[0].s;
                    read_index <= pending_cmds[0].idx;
                    void'(pending_cmds.pop_front());
                    in_valid <= 1;
                    if ($urandom_range(0, 49) == 0)
                        send_idle <= !send_idle;
                    send_gap <= send_idle ? $urandom_range(0, 19) : 0;
                end
                else
                begin
                    in_valid <= 0;
                end
            end
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            held <= 0;
        end
        else if (!held && words_out >= 400)
        begin
            hold_cnt <= 2000;
            held <= 1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: compare each delivered result word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        resp_t e;
        int next_wait;
        if (!rst_n)
        begin
            out_ready <= 0;
            recv_wait <= 0;
            recv_idle <= 0;
        end
        else
        begin
            next_wait = (recv_wait > 0) ? recv_wait - 1 : 0;
            if (out_valid && out_ready)
            begin
                words_out++;
                if (expected_resps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: status %0d count %0d",
                                 status, entry_count);
                end
                else
                begin
                    e = expected_resps.pop_front();
                    if (status !== e.st || entry_count !== e.cnt
                        || {out_name_word3, out_name_word2, out_name_word1,
                            out_name_word0} !== e.name
                        || record_time !== e.t || best_speed !== e.s
                        || tied_rank !== e.rank)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch on word %0d: expected st %0d cnt %0d t %0d s %0d rank %0d name %h",
                                     words_out, e.st, e.cnt, e.t, e.s, e.rank, e.name);
                            $display("  actual st %0d cnt %0d t %0d s %0d rank %0d name %h",
                                     status, entry_count, record_time, best_speed, tied_rank,
                                     {out_name_word3, out_name_word2, out_name_word1,
                                      out_name_word0});
                        end
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    recv_idle <= !recv_idle;
                next_wait = recv_idle ? $urandom_range(0, 19) : 0;
            end
            recv_wait <= next_wait;
            out_ready <= (next_wait == 0 && hold_cnt == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
